@@ sv/pps_pkg.sv @@
package pps_pkg;

  // default table size
  localparam int MAX_PROCS_DEF = 16;

  // field widths
  localparam int ID_W     = 8;
  localparam int TIME_W   = 32;
  localparam int PRIO_W   = 8;
  localparam int BURST_W  = 16;
  localparam int SUM_W    = 48;
  localparam int STATUS_W = 2;

  // stream payload widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 208;

  // item kinds
  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_BURST = 2'd2;

  // one process table entry
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
  } slot_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic free_rd;
    logic commit;
    logic pend_rd;
    logic admit;
    logic run_rd;
    logic exec;
    logic fin_tat;
    logic fin_wt;
    logic out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pend_empty;
    logic admit_ok;
    logic ready_empty;
    logic done_zero;
    logic out_free;
  } stat_t;

endpackage

@@ sv/pps_dp.sv @@
module pps_dp #(
  parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pps_pkg::cmd_t                       cmd,
  output pps_pkg::stat_t                      stat,
  input  logic [pps_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic                                s_tuser,
  output logic [pps_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic [1:0]                          m_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready
);

  localparam int IW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam logic [CW-1:0] N_C  = CW'(MAX_PROCS);
  localparam logic [IW:0]   N_W  = (IW + 1)'(MAX_PROCS);
  localparam logic [IW-1:0] LAST = IW'(MAX_PROCS - 1);
  localparam int PAD_W = pps_pkg::OUT_TDATA_W - 202;

  // latched input item
  logic                          in_op;
  logic [pps_pkg::ID_W-1:0]      in_id;
  logic [pps_pkg::TIME_W-1:0]    in_arr;
  logic [pps_pkg::PRIO_W-1:0]    in_prio;
  logic [pps_pkg::BURST_W-1:0]   in_burst;

  // counters and pointers
  logic [CW-1:0] used_cnt, fresh_cnt, pend_cnt, ready_cnt;
  logic [IW-1:0] free_head, free_tail, pend_head;
  logic [pps_pkg::TIME_W-1:0] cur_time;
  logic [pps_pkg::SUM_W-1:0]  sum_tat, sum_wt;
  logic [pps_pkg::STATUS_W-1:0] sub_status;
  logic ran_f, fin_f;

  // memories
  pps_pkg::slot_t             slot_mem [MAX_PROCS];
  logic [IW-1:0]              free_mem [MAX_PROCS];
  logic [IW-1:0]              pend_slot_mem [MAX_PROCS];
  logic [pps_pkg::TIME_W-1:0] pend_arr_mem [MAX_PROCS];
  logic [pps_pkg::PRIO_W-1:0] pend_prio_mem [MAX_PROCS];

  // registered read data and run registers
  pps_pkg::slot_t             slot_q;
  logic [IW-1:0]              free_q, pend_slot_q, run_slot;
  logic [pps_pkg::TIME_W-1:0] pend_arr_q, tat_q, wt_q;
  logic [pps_pkg::PRIO_W-1:0] pend_prio_q, run_prio;
  logic [pps_pkg::BURST_W-1:0] burst_q;
  logic [pps_pkg::ID_W-1:0]   id_q;

  // ready list, one cell per place, kept sorted by priority
  logic [IW-1:0]              rdy_slot [MAX_PROCS];
  logic [pps_pkg::PRIO_W-1:0] rdy_prio [MAX_PROCS];
  logic [IW-1:0]              ins_row_slot [MAX_PROCS];
  logic [pps_pkg::PRIO_W-1:0] ins_row_prio [MAX_PROCS];
  logic [MAX_PROCS-1:0]       gt;
  logic [IW-1:0]              ins_slot;
  logic [pps_pkg::PRIO_W-1:0] ins_prio;

  logic [IW:0]    tail_sum;
  logic [IW-1:0]  pend_tail, new_slot;
  logic           sub_ok, fresh_left;
  logic [pps_pkg::BURST_W-1:0] rem_new;
  logic           reinsert;
  logic [pps_pkg::SUM_W:0] tat_sum, wt_sum;

  // slot memory write port
  logic           slot_we;
  logic [IW-1:0]  slot_wa;
  pps_pkg::slot_t slot_wd;

  // pending fifo tail and slot choice
  assign tail_sum   = {1'b0, pend_head} + (IW + 1)'(pend_cnt);
  assign pend_tail  = (tail_sum >= N_W) ? IW'(tail_sum - N_W) : tail_sum[IW-1:0];
  assign fresh_left = (fresh_cnt < N_C);
  assign new_slot   = fresh_left ? fresh_cnt[IW-1:0] : free_q;
  assign sub_ok     = (sub_status == pps_pkg::STATUS_OK);
  assign rem_new    = slot_q.remaining - 1'b1;
  assign reinsert   = cmd.exec && (rem_new != '0);

  // saturating total sums
  assign tat_sum = {1'b0, sum_tat} + (pps_pkg::SUM_W + 1)'(tat_q);
  assign wt_sum  = {1'b0, sum_wt} + (pps_pkg::SUM_W + 1)'(wt_q);

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
    return (p == LAST) ? '0 : IW'(p + 1'b1);
  endfunction

  // status to controller
  assign stat.pend_empty  = (pend_cnt == '0);
  assign stat.admit_ok    = (pend_arr_q <= cur_time);
  assign stat.ready_empty = (ready_cnt == '0);
  assign stat.done_zero   = (rem_new == '0);
  assign stat.out_free    = !m_tvalid || m_tready;

  // sorted insert: entries of greater priority move up one place
  assign ins_slot = cmd.admit ? pend_slot_q : run_slot;
  assign ins_prio = cmd.admit ? pend_prio_q : run_prio;

  always_comb begin
    for (int k = 0; k < MAX_PROCS; k++) begin
      gt[k] = (CW'(k) >= ready_cnt) || (rdy_prio[k] > ins_prio);
    end
    ins_row_slot[0] = gt[0] ? ins_slot : rdy_slot[0];
    ins_row_prio[0] = gt[0] ? ins_prio : rdy_prio[0];
    for (int k = 1; k < MAX_PROCS; k++) begin
      if (!gt[k]) begin
        ins_row_slot[k] = rdy_slot[k];
        ins_row_prio[k] = rdy_prio[k];
      end else if (!gt[k-1]) begin
        ins_row_slot[k] = ins_slot;
        ins_row_prio[k] = ins_prio;
      end else begin
        ins_row_slot[k] = rdy_slot[k-1];
        ins_row_prio[k] = rdy_prio[k-1];
      end
    end
  end

  // ready list cells
  always_ff @(posedge clk) begin
    if (cmd.admit || reinsert) begin
      for (int k = 0; k < MAX_PROCS; k++) begin
        rdy_slot[k] <= ins_row_slot[k];
        rdy_prio[k] <= ins_row_prio[k];
      end
    end else if (cmd.run_rd) begin
      for (int k = 0; k < MAX_PROCS - 1; k++) begin
        rdy_slot[k] <= rdy_slot[k+1];
        rdy_prio[k] <= rdy_prio[k+1];
      end
    end
  end

  // slot memory write select
  always_comb begin
    slot_we = 1'b0;
    slot_wa = run_slot;
    slot_wd = slot_q;
    slot_wd.remaining = rem_new;
    if (cmd.commit && sub_ok) begin
      slot_we = 1'b1;
      slot_wa = new_slot;
      slot_wd = '{id: in_id, arrival: in_arr, burst: in_burst, remaining: in_burst};
    end else if (cmd.exec) begin
      slot_we = 1'b1;
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      used_cnt   <= '0;
      fresh_cnt  <= '0;
      pend_cnt   <= '0;
      ready_cnt  <= '0;
      free_head  <= '0;
      free_tail  <= '0;
      pend_head  <= '0;
      cur_time   <= '0;
      sum_tat    <= '0;
      sum_wt     <= '0;
      m_tvalid   <= 1'b0;
      ran_f      <= 1'b0;
      fin_f      <= 1'b0;
      sub_status <= pps_pkg::STATUS_OK;
    end else begin
      if (m_tvalid && m_tready && !cmd.out_load) m_tvalid <= 1'b0;
      if (cmd.load_in) begin
        ran_f <= 1'b0;
        fin_f <= 1'b0;
      end
      if (cmd.free_rd) begin
        if (in_burst == '0) sub_status <= pps_pkg::STATUS_ZERO_BURST;
        else if (used_cnt == N_C) sub_status <= pps_pkg::STATUS_FULL;
        else sub_status <= pps_pkg::STATUS_OK;
      end
      if (cmd.commit && sub_ok) begin
        used_cnt <= used_cnt + 1'b1;
        pend_cnt <= pend_cnt + 1'b1;
        if (fresh_left) fresh_cnt <= fresh_cnt + 1'b1;
        else free_head <= ptr_inc(free_head);
      end
      if (cmd.admit) begin
        pend_head <= ptr_inc(pend_head);
        pend_cnt  <= pend_cnt - 1'b1;
        ready_cnt <= ready_cnt + 1'b1;
      end
      if (cmd.run_rd) begin
        ready_cnt <= ready_cnt - 1'b1;
        ran_f     <= 1'b1;
      end
      if (cmd.exec) begin
        if (rem_new == '0) begin
          fin_f     <= 1'b1;
          free_tail <= ptr_inc(free_tail);
          used_cnt  <= used_cnt - 1'b1;
        end else begin
          ready_cnt <= ready_cnt + 1'b1;
        end
      end
      if (cmd.fin_tat) sum_tat <= tat_sum[pps_pkg::SUM_W] ? '1 : tat_sum[pps_pkg::SUM_W-1:0];
      if (cmd.fin_wt) sum_wt <= wt_sum[pps_pkg::SUM_W] ? '1 : wt_sum[pps_pkg::SUM_W-1:0];
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
        if (in_op == pps_pkg::OP_TICK) cur_time <= cur_time + 1'b1;
      end
    end
  end

  // memories, read data and payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_op    <= s_tuser;
      in_id    <= s_tdata[7:0];
      in_arr   <= s_tdata[39:8];
      in_prio  <= s_tdata[47:40];
      in_burst <= s_tdata[63:48];
    end
    if (cmd.free_rd) free_q <= free_mem[free_head];
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (cmd.commit && sub_ok) begin
      pend_slot_mem[pend_tail] <= new_slot;
      pend_arr_mem[pend_tail]  <= in_arr;
      pend_prio_mem[pend_tail] <= in_prio;
    end
    if (cmd.pend_rd) begin
      pend_slot_q <= pend_slot_mem[pend_head];
      pend_arr_q  <= pend_arr_mem[pend_head];
      pend_prio_q <= pend_prio_mem[pend_head];
    end
    if (cmd.run_rd) begin
      slot_q   <= slot_mem[rdy_slot[0]];
      run_slot <= rdy_slot[0];
      run_prio <= rdy_prio[0];
    end
    if (cmd.exec) begin
      if (rem_new == '0) free_mem[free_tail] <= run_slot;
      tat_q   <= cur_time - slot_q.arrival + 1'b1;
      burst_q <= slot_q.burst;
      id_q    <= slot_q.id;
    end
    if (cmd.fin_tat) wt_q <= tat_q - pps_pkg::TIME_W'(burst_q);
    if (cmd.out_load) begin
      m_tdata <= {{PAD_W{1'b0}}, sum_wt, sum_tat,
                  fin_f ? wt_q : '0,
                  fin_f ? tat_q : '0,
                  fin_f ? cur_time : '0,
                  ran_f ? id_q : '0,
                  (in_op == pps_pkg::OP_SUBMIT) ? sub_status : pps_pkg::STATUS_OK};
      m_tuser <= {fin_f, ran_f};
    end
  end

endmodule

@@ sv/pps_ctrl.sv @@
module pps_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           op,
  input  pps_pkg::stat_t stat,
  output pps_pkg::cmd_t  cmd,
  output logic           s_tready
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SUB_RD  = 4'd1;
  localparam logic [3:0] S_SUB_WR  = 4'd2;
  localparam logic [3:0] S_ADM_RD  = 4'd3;
  localparam logic [3:0] S_ADM_CHK = 4'd4;
  localparam logic [3:0] S_RUN     = 4'd5;
  localparam logic [3:0] S_EXEC    = 4'd6;
  localparam logic [3:0] S_FIN_TAT = 4'd7;
  localparam logic [3:0] S_FIN_WT  = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  logic [3:0] state, state_next;

  assign s_tready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next = (op == pps_pkg::OP_SUBMIT) ? S_SUB_RD : S_ADM_RD;
        end
      end
      S_SUB_RD: begin
        cmd.free_rd = 1'b1;
        state_next = S_SUB_WR;
      end
      S_SUB_WR: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_ADM_RD: begin
        if (stat.pend_empty) begin
          state_next = S_RUN;
        end else begin
          cmd.pend_rd = 1'b1;
          state_next = S_ADM_CHK;
        end
      end
      S_ADM_CHK: begin
        if (stat.admit_ok) begin
          cmd.admit = 1'b1;
          state_next = S_ADM_RD;
        end else begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (stat.ready_empty) begin
          state_next = S_OUT;
        end else begin
          cmd.run_rd = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = stat.done_zero ? S_FIN_TAT : S_OUT;
      end
      S_FIN_TAT: begin
        cmd.fin_tat = 1'b1;
        state_next = S_FIN_WT;
      end
      S_FIN_WT: begin
        cmd.fin_wt = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

@@ sv/preemptive_priority_scheduler.sv @@
// Preemptive priority scheduler. Each input item is either a process submission
// (tuser 0) or a time tick (tuser 1); each gives exactly one result item. A submit
// checks the item and reads the free slot list, then writes the table and pending fifo,
// and then its result is registered. A tick admits pending processes into the ready
// list in submission order, one pending fifo read and one sorted insert per process,
// and stops at the first pending head that has not yet arrived; it then runs the head
// of the ready list, if any, and on completion adds its times to the totals before the
// result is registered. Items are taken one at a time, and the next item is accepted
// as soon as the result has been registered; a stalled result holds the block until it
// is taken. Submissions with a zero burst or a full table are flagged in status and
// change nothing; running totals saturate.
module preemptive_priority_scheduler #(
  parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // proc_id[7:0], arrival_time[39:8], priority_level[47:40], burst_length[63:48]
  input  logic [pps_pkg::IN_TDATA_W-1:0]  s_tdata,
  // opcode
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status[1:0], ran_id[9:2], finish_time[41:10], turnaround_time[73:42],
  // waiting_time[105:74], total_turnaround[153:106], total_waiting[201:154]
  output logic [pps_pkg::OUT_TDATA_W-1:0] m_tdata,
  // ran_valid[0], finished[1]
  output logic [1:0]                      m_tuser
);

  pps_pkg::cmd_t  cmd;
  pps_pkg::stat_t stat;

  // sequencer
  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (s_tuser),
    .stat     (stat),
    .cmd      (cmd),
    .s_tready (s_tready)
  );

  // tables, lists and arithmetic
  pps_dp #(.MAX_PROCS(MAX_PROCS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  // a completion is always reported on a tick that ran a process
  a_fin_ran: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0])
    else $error("finished without ran_valid");

  // a flagged submit never reports a run
  a_flag_norun: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != pps_pkg::STATUS_OK) |-> !m_tuser[0])
    else $error("flagged submit reports a run");

  // one item at a time: input closes after acceptance
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input still open after acceptance");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int NSLOT       = pps_pkg::MAX_PROCS_DEF;
  localparam int IDLE_MAX    = 5000;
  localparam int DRAIN_CYC   = 60;
  localparam int STATUS_W    = pps_pkg::STATUS_W;
  localparam int ID_W        = pps_pkg::ID_W;
  localparam int TIME_W      = pps_pkg::TIME_W;
  localparam int PRIO_W      = pps_pkg::PRIO_W;
  localparam int BURST_W     = pps_pkg::BURST_W;
  localparam int SUM_W       = pps_pkg::SUM_W;
  localparam int IN_TDATA_W  = pps_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = pps_pkg::OUT_TDATA_W;

  // one scheduler result
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                ran_valid;
    logic [ID_W-1:0]     ran_id;
    logic                finished;
    logic [TIME_W-1:0]   finish_time;
    logic [TIME_W-1:0]   turnaround;
    logic [TIME_W-1:0]   waiting;
    logic [SUM_W-1:0]    tot_turnaround;
    logic [SUM_W-1:0]    tot_waiting;
  } sched_result_t;

  // directed stimulus row; status is typed in where check_status is set
  typedef struct packed {
    logic                op;
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   arrival;
    logic [PRIO_W-1:0]   prio;
    logic [BURST_W-1:0]  burst;
    logic                check_status;
    logic [STATUS_W-1:0] status;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = pps_pkg::OP_TICK;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [1:0]             m_tuser;

  preemptive_priority_scheduler u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  // scheduler state mirror
  logic [ID_W-1:0]    sl_id     [NSLOT];
  logic [TIME_W-1:0]  sl_arrival[NSLOT];
  logic [PRIO_W-1:0]  sl_prio   [NSLOT];
  logic [BURST_W-1:0] sl_burst  [NSLOT];
  logic [BURST_W-1:0] sl_left   [NSLOT];
  logic               sl_busy   [NSLOT];
  int                 ready_q[$];
  int                 pending_q[$];
  logic [TIME_W-1:0]  now_tick;
  logic [SUM_W-1:0]   sum_tat, sum_wt;

  sched_result_t result_q[$];
  int  errors = 0;
  int  n_items = 0, n_results = 0, n_finished = 0, n_full = 0, n_zero = 0;
  int  idle_cycles = 0;

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [TIME_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W + 1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  // place a slot after all ready entries of equal or better priority
  function automatic void ready_place(int s);
    int pos;
    pos = 0;
    while (pos < ready_q.size() && sl_prio[ready_q[pos]] <= sl_prio[s]) pos++;
    ready_q.insert(pos, s);
  endfunction

  function automatic sched_result_t schedule_step(logic op, logic [ID_W-1:0] id,
      logic [TIME_W-1:0] arr, logic [PRIO_W-1:0] prio, logic [BURST_W-1:0] burst);
    sched_result_t r;
    int s;
    r = '0;
    if (op == pps_pkg::OP_SUBMIT) begin
      s = -1;
      for (int k = NSLOT - 1; k >= 0; k--) if (!sl_busy[k]) s = k;
      if (burst == 0) begin
        r.status = pps_pkg::STATUS_ZERO_BURST;
      end else if (s < 0 || pending_q.size() >= NSLOT) begin
        r.status = pps_pkg::STATUS_FULL;
      end else begin
        sl_id[s] = id; sl_arrival[s] = arr; sl_prio[s] = prio;
        sl_burst[s] = burst; sl_left[s] = burst; sl_busy[s] = 1'b1;
        pending_q.push_back(s);
      end
    end else begin
      // admit in submission order, stop at the first future arrival
      while (pending_q.size() > 0 && sl_arrival[pending_q[0]] <= now_tick)
        ready_place(pending_q.pop_front());
      if (ready_q.size() > 0) begin
        s = ready_q.pop_front();
        sl_left[s] = sl_left[s] - 1'b1;
        r.ran_valid = 1'b1;
        r.ran_id = sl_id[s];
        if (sl_left[s] == 0) begin
          r.finished = 1'b1;
          r.finish_time = now_tick;
          r.turnaround = now_tick - sl_arrival[s] + 32'd1;
          r.waiting = r.turnaround - TIME_W'(sl_burst[s]);
          sum_tat = sat_sum(sum_tat, r.turnaround);
          sum_wt = sat_sum(sum_wt, r.waiting);
          sl_busy[s] = 1'b0;
        end else begin
          ready_place(s);
        end
      end
      now_tick = now_tick + 32'd1;
    end
    r.tot_turnaround = sum_tat;
    r.tot_waiting = sum_wt;
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // present one item, wait for acceptance, record its expected result
  task automatic send_item(logic op, logic [ID_W-1:0] id, logic [TIME_W-1:0] arr,
      logic [PRIO_W-1:0] prio, logic [BURST_W-1:0] burst, logic chk = 1'b0,
      logic [STATUS_W-1:0] st = pps_pkg::STATUS_OK);
    int gap;
    sched_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {burst, prio, arr, id};
    do @(posedge clk); while (!s_tready);
    r = schedule_step(op, id, arr, prio, burst);
    if (chk && r.status !== st) begin
      $display("%0t: status table mismatch expected %0d actual %0d", $time, st, r.status);
      errors++;
    end
    if (r.status == pps_pkg::STATUS_FULL) n_full++;
    if (r.status == pps_pkg::STATUS_ZERO_BURST) n_zero++;
    result_q.push_back(r);
    n_items++;
  endtask

  // result side: random stalls and field checks
  int stall_left = 0;
  always @(posedge clk) begin
    sched_result_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got.status         = m_tdata[1:0];
      got.ran_id         = m_tdata[9:2];
      got.finish_time    = m_tdata[41:10];
      got.turnaround     = m_tdata[73:42];
      got.waiting        = m_tdata[105:74];
      got.tot_turnaround = m_tdata[153:106];
      got.tot_waiting    = m_tdata[201:154];
      got.ran_valid      = m_tuser[0];
      got.finished       = m_tuser[1];
      n_results++;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected item actual %h", $time, got);
        errors++;
      end else begin
        exp_r = result_q.pop_front();
        if (got.finished && exp_r.finished) n_finished++;
        if (got.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
          errors++;
        end
        if (got.ran_valid !== exp_r.ran_valid) begin
          $display("%0t: ran_valid expected %0b actual %0b", $time, exp_r.ran_valid,
                   got.ran_valid);
          errors++;
        end
        if (got.ran_id !== exp_r.ran_id) begin
          $display("%0t: ran_id expected %0d actual %0d", $time, exp_r.ran_id, got.ran_id);
          errors++;
        end
        if (got.finished !== exp_r.finished) begin
          $display("%0t: finished expected %0b actual %0b", $time, exp_r.finished,
                   got.finished);
          errors++;
        end
        if (got.finish_time !== exp_r.finish_time) begin
          $display("%0t: finish_time expected %0d actual %0d", $time, exp_r.finish_time,
                   got.finish_time);
          errors++;
        end
        if (got.turnaround !== exp_r.turnaround) begin
          $display("%0t: turnaround expected %0d actual %0d", $time, exp_r.turnaround,
                   got.turnaround);
          errors++;
        end
        if (got.waiting !== exp_r.waiting) begin
          $display("%0t: waiting expected %0d actual %0d", $time, exp_r.waiting,
                   got.waiting);
          errors++;
        end
        if (got.tot_turnaround !== exp_r.tot_turnaround) begin
          $display("%0t: total_turnaround expected %0d actual %0d", $time,
                   exp_r.tot_turnaround, got.tot_turnaround);
          errors++;
        end
        if (got.tot_waiting !== exp_r.tot_waiting) begin
          $display("%0t: total_waiting expected %0d actual %0d", $time,
                   exp_r.tot_waiting, got.tot_waiting);
          errors++;
        end
      end
    end
    // stall pattern: mostly short, a few long, runs without any
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 99) < 20) stall_left <= pick_gap();
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 result_q.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // directed rows: empty tick, zero burst, field extremes, priority ties,
  // late arrival blocking later submissions
  dir_row_t dir_rows[22] = '{
    '{pps_pkg::OP_TICK,   8'd0,   32'd0,  8'd0,   16'd0, 1'b1, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_SUBMIT, 8'd9,   32'd0,  8'd1,   16'd0, 1'b1, pps_pkg::STATUS_ZERO_BURST},
    '{pps_pkg::OP_SUBMIT, 8'd255, 32'd0,  8'd255, 16'd1, 1'b1, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_SUBMIT, 8'd0,   32'd1,  8'd0,   16'd2, 1'b1, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_SUBMIT, 8'd7,   32'd1,  8'd0,   16'd1, 1'b1, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_SUBMIT, 8'd3,   32'd2,  8'd0,   16'd2, 1'b1, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_TICK,   8'd0,   32'd0,  8'd0,   16'd0, 1'b0, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_TICK,   8'd0,   32'd0,  8'd0,   16'd0, 1'b0, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_TICK,   8'd0,   32'd0,  8'd0,   16'd0, 1'b0, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_TICK,   8'd0,   32'd0,  8'd0,   16'd0, 1'b0, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_TICK,   8'd0,   32'd0,  8'd0,   16'd0, 1'b0, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_TICK,   8'd0,   32'd0,  8'd0,   16'd0, 1'b0, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_TICK,   8'd0,   32'd0,  8'd0,   16'd0, 1'b0, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_SUBMIT, 8'd20,  32'd12, 8'd4,   16'd1, 1'b1, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_SUBMIT, 8'd21,  32'd3,  8'd2,   16'd1, 1'b1, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_TICK,   8'd0,   32'd0,  8'd0,   16'd0, 1'b0, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_TICK,   8'd0,   32'd0,  8'd0,   16'd0, 1'b0, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_TICK,   8'd0,   32'd0,  8'd0,   16'd0, 1'b0, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_TICK,   8'd0,   32'd0,  8'd0,   16'd0, 1'b0, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_TICK,   8'd0,   32'd0,  8'd0,   16'd0, 1'b0, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_TICK,   8'd0,   32'd0,  8'd0,   16'd0, 1'b0, pps_pkg::STATUS_OK},
    '{pps_pkg::OP_TICK,   8'd0,   32'd0,  8'd0,   16'd0, 1'b0, pps_pkg::STATUS_OK}
  };

  initial begin
    logic [TIME_W-1:0] arr;
    logic [BURST_W-1:0] bl;
    logic [PRIO_W-1:0] pr;
    int p;
    for (int k = 0; k < NSLOT; k++) sl_busy[k] = 1'b0;
    now_tick = '0; sum_tat = '0; sum_wt = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].id, dir_rows[i].arrival, dir_rows[i].prio,
                dir_rows[i].burst, dir_rows[i].check_status, dir_rows[i].status);

    // hold the sender until the result side has drained
    s_tvalid <= 1'b0;
    wait (result_q.size() == 0);
    @(posedge clk);

    // random traffic: arrivals near the current tick, small bursts, some ties
    for (int n = 0; n < 1360; n++) begin
      p = $urandom_range(0, 99);
      if (p < 42) begin
        arr = now_tick + TIME_W'($urandom_range(0, 4));
        if ($urandom_range(0, 9) == 0) arr = now_tick - TIME_W'($urandom_range(0, 5));
        pr = ($urandom_range(0, 1) != 0) ? PRIO_W'($urandom_range(0, 3))
                                         : PRIO_W'($urandom_range(0, 255));
        bl = ($urandom_range(0, 19) == 0) ? 16'd0 : BURST_W'($urandom_range(1, 6));
        send_item(pps_pkg::OP_SUBMIT, ID_W'($urandom_range(0, 255)), arr, pr, bl);
      end else begin
        send_item(pps_pkg::OP_TICK, ID_W'($urandom), TIME_W'($urandom),
                  PRIO_W'($urandom), BURST_W'($urandom));
      end
    end

    // far arrivals and long bursts: table fills up and stays blocked
    for (int n = 0; n < 40; n++) begin
      if (n % 3 == 2)
        send_item(pps_pkg::OP_TICK, '0, '0, '0, '0);
      else
        send_item(pps_pkg::OP_SUBMIT, ID_W'($urandom_range(0, 255)), TIME_W'($urandom),
                  PRIO_W'($urandom_range(0, 255)),
                  ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)),
                  1'b0, pps_pkg::STATUS_OK);
    end
    send_item(pps_pkg::OP_SUBMIT, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    send_item(pps_pkg::OP_SUBMIT, 8'h00, 32'h0000_0000, 8'h00, 16'hFFFF);
    s_tvalid <= 1'b0;

    wait (result_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    $display("%0d items sent, %0d results checked: %0d completions, %0d table full,",
             n_items, n_results, n_finished, n_full);
    $display("%0d zero bursts rejected, final tick %0d", n_zero, now_tick);
    if (errors == 0 && result_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/pps_pkg.sv
sv/pps_dp.sv
sv/pps_ctrl.sv
sv/preemptive_priority_scheduler.sv
tb/sv/testbench.sv
